// ===== hw/rtl/led_pixel_stream_encoder_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the LED pixel stream encoder
// Concurrent assertion shorthands, clocked; one is reset-qualified, one is not.
// ----------------------------------------------------------------------------
`ifndef LED_PIXEL_STREAM_ENCODER_UNIT_ASSERT_SVH
`define LED_PIXEL_STREAM_ENCODER_UNIT_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define LPSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent, reset included.
`define LPSE_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/lpse_pkg.sv =====
// ----------------------------------------------------------------------------
// lpse_pkg
// Shared types and constants of the LED pixel stream encoder.
// ----------------------------------------------------------------------------
package lpse_pkg;

    localparam int HEADER_BYTES   = 2;
    localparam int TRAILER_BYTES  = 32;
    localparam int DATA_BYTES_MAX = 16;
    localparam int QUEUE_DEPTH    = 2;

    localparam int CNT_SPAN = (HEADER_BYTES > TRAILER_BYTES)
                              ? ((HEADER_BYTES > DATA_BYTES_MAX) ? HEADER_BYTES : DATA_BYTES_MAX)
                              : ((TRAILER_BYTES > DATA_BYTES_MAX) ? TRAILER_BYTES : DATA_BYTES_MAX);
    localparam int CNT_W    = $clog2(CNT_SPAN);
    localparam int QPTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;

    localparam logic [7:0] BRIGHT_HDR_BASE = 8'hE0;
    localparam logic [7:0] CHAN_MAX        = 8'hFF;

    typedef enum logic [1:0] {
        MODE_PLAIN   = 2'd0,
        MODE_BRIGHT  = 2'd1,
        MODE_PULSE   = 2'd2,
        MODE_PULSE_W = 2'd3
    } t_led_mode;

    typedef enum logic [2:0] {
        ORD_RGB = 3'd0,
        ORD_RBG = 3'd1,
        ORD_GRB = 3'd2,
        ORD_BGR = 3'd3,
        ORD_BRG = 3'd4,
        ORD_GBR = 3'd5
    } t_color_order;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LED_MODE    = 3'd0,
        CFG_COLOR_ORDER = 3'd1,
        CFG_BRIGHTNESS  = 3'd2,
        CFG_DITHER_EN   = 3'd3,
        CFG_DITHER_PH   = 3'd4,
        CFG_ZERO_CODE   = 3'd5,
        CFG_ONE_CODE    = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        t_led_mode   led_mode;
        logic [2:0]  color_order;
        logic [4:0]  global_brightness;
        logic        dither_enable;
        logic [1:0]  dither_phase;
        logic [3:0]  zero_pulse_code;
        logic [3:0]  one_pulse_code;
    } t_cfg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] white;
        logic [5:0] dither_bits;
        logic       frame_start;
        logic       frame_end;
    } t_pixel;

    // Decoded pixel: channels already dithered and in send order, white last.
    typedef struct packed {
        logic [3:0][7:0] chan;
        t_led_mode       mode;
        logic [7:0]      bright_byte;
        logic            frame_start;
        logic            frame_end;
    } t_job;

endpackage

// ===== hw/rtl/lpse_pixel_if.sv =====
// ----------------------------------------------------------------------------
// lpse_pixel_if
// Valid/ready channel carrying one pixel per transaction.
// ----------------------------------------------------------------------------
interface lpse_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] white;
    logic [5:0] dither_bits;
    logic       frame_start;
    logic       frame_end;

    modport source (
        output valid, red, green, blue, white, dither_bits, frame_start, frame_end,
        input  ready
    );
    modport sink (
        input  valid, red, green, blue, white, dither_bits, frame_start, frame_end,
        output ready
    );
endinterface

// ===== hw/rtl/lpse_byte_if.sv =====
// ----------------------------------------------------------------------------
// lpse_byte_if
// Valid/ready channel carrying one serial stream byte per transaction.
// ----------------------------------------------------------------------------
interface lpse_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;

    modport source (
        output valid, out_byte, run_last,
        input  ready
    );
    modport sink (
        input  valid, out_byte, run_last,
        output ready
    );
endinterface

// ===== hw/rtl/lpse_front.sv =====
// ----------------------------------------------------------------------------
// lpse_front
// Accepts pixels, applies dither and channel order, builds a job for the queue.
// ----------------------------------------------------------------------------
module lpse_front (
    input  lpse_pkg::t_cfg   i_cfg,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  lpse_pkg::t_pixel i_pixel,
    input  logic             i_q_full,
    output logic             o_push,
    output lpse_pkg::t_job   o_job
);
    import lpse_pkg::*;

    logic       dith_on;
    logic [7:0] red_d;
    logic [7:0] green_d;
    logic [7:0] blue_d;

    function automatic logic [7:0] dither_chan(
        input logic [7:0] v,
        input logic [1:0] d,
        input logic [1:0] ph
    );
        if (v != CHAN_MAX && d > ph) begin
            return v + 8'd1;
        end
        return v;
    endfunction

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // Dither is skipped in the RGBW pulse mode.
    assign dith_on = i_cfg.dither_enable && (i_cfg.led_mode != MODE_PULSE_W);

    always_comb begin
        red_d   = i_pixel.red;
        green_d = i_pixel.green;
        blue_d  = i_pixel.blue;
        if (dith_on) begin
            red_d   = dither_chan(i_pixel.red,   i_pixel.dither_bits[5:4], i_cfg.dither_phase);
            green_d = dither_chan(i_pixel.green, i_pixel.dither_bits[3:2], i_cfg.dither_phase);
            blue_d  = dither_chan(i_pixel.blue,  i_pixel.dither_bits[1:0], i_cfg.dither_phase);
        end
    end

    always_comb begin
        o_job.mode        = i_cfg.led_mode;
        o_job.bright_byte = BRIGHT_HDR_BASE | {3'b000, i_cfg.global_brightness};
        o_job.frame_start = i_pixel.frame_start;
        o_job.frame_end   = i_pixel.frame_end;
        o_job.chan[3]     = i_pixel.white;
        unique case (t_color_order'(i_cfg.color_order))
            ORD_RBG: begin
                o_job.chan[0] = red_d;   o_job.chan[1] = blue_d;  o_job.chan[2] = green_d;
            end
            ORD_GRB: begin
                o_job.chan[0] = green_d; o_job.chan[1] = red_d;   o_job.chan[2] = blue_d;
            end
            ORD_BGR: begin
                o_job.chan[0] = blue_d;  o_job.chan[1] = green_d; o_job.chan[2] = red_d;
            end
            ORD_BRG: begin
                o_job.chan[0] = blue_d;  o_job.chan[1] = red_d;   o_job.chan[2] = green_d;
            end
            ORD_GBR: begin
                o_job.chan[0] = green_d; o_job.chan[1] = blue_d;  o_job.chan[2] = red_d;
            end
            default: begin
                o_job.chan[0] = red_d;   o_job.chan[1] = green_d; o_job.chan[2] = blue_d;
            end
        endcase
    end

endmodule

// ===== hw/rtl/lpse_queue.sv =====
// ----------------------------------------------------------------------------
// lpse_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module lpse_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lpse_pkg::t_job i_data,
    output logic           o_full,
    output logic           o_valid,
    output lpse_pkg::t_job o_data,
    input  logic           i_pop
);
    import lpse_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    assign n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== hw/rtl/lpse_back.sv =====
// ----------------------------------------------------------------------------
// lpse_back
// Byte sequencer: walks header zeros, brightness byte, data and trailer zeros.
// ----------------------------------------------------------------------------
module lpse_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lpse_pkg::t_cfg i_cfg,
    input  logic           i_q_valid,
    input  lpse_pkg::t_job i_q_data,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [7:0]     o_out_byte,
    output logic           o_out_last
);
    import lpse_pkg::*;

    typedef enum logic [3:0] {
        PH_HEAD   = 4'b0001,
        PH_BRIGHT = 4'b0010,
        PH_DATA   = 4'b0100,
        PH_TAIL   = 4'b1000
    } t_phase;

    t_job             r_job;
    logic             r_busy;
    t_phase           r_phase;
    logic [CNT_W-1:0] r_cnt;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;

    t_phase           n_phase;
    logic [CNT_W-1:0] n_cnt;
    logic [7:0]       cur_byte;
    logic             job_done;
    logic             adv;
    logic             emit;
    logic             is_pulse;
    logic [CNT_W-1:0] data_last;
    logic [7:0]       pulse_src;
    logic [7:0]       pulse_shift;
    logic [7:0]       pulse_byte;

    function automatic t_phase after_head(input t_job j);
        return (j.mode == MODE_BRIGHT) ? PH_BRIGHT : PH_DATA;
    endfunction

    function automatic t_phase first_phase(input t_job j);
        if (j.frame_start && HEADER_BYTES != 0) begin
            return PH_HEAD;
        end
        return after_head(j);
    endfunction

    assign is_pulse = (r_job.mode == MODE_PULSE) || (r_job.mode == MODE_PULSE_W);

    always_comb begin
        unique case (r_job.mode)
            MODE_PULSE:   data_last = CNT_W'(11);
            MODE_PULSE_W: data_last = CNT_W'(15);
            default:      data_last = CNT_W'(2);
        endcase
    end

    // Pulse byte k of a channel carries data bits 7-2k and 6-2k.
    assign pulse_src   = r_job.chan[r_cnt[3:2]];
    assign pulse_shift = pulse_src << {r_cnt[1:0], 1'b0};
    assign pulse_byte  = {pulse_shift[7] ? i_cfg.one_pulse_code : i_cfg.zero_pulse_code,
                          pulse_shift[6] ? i_cfg.one_pulse_code : i_cfg.zero_pulse_code};

    always_comb begin
        cur_byte = '0;
        job_done = 1'b0;
        n_phase  = r_phase;
        n_cnt    = r_cnt + 1'b1;
        unique case (r_phase)
            PH_HEAD: begin
                if (r_cnt == CNT_W'(HEADER_BYTES - 1)) begin
                    n_phase = after_head(r_job);
                    n_cnt   = '0;
                end
            end
            PH_BRIGHT: begin
                cur_byte = r_job.bright_byte;
                n_phase  = PH_DATA;
                n_cnt    = '0;
            end
            PH_DATA: begin
                cur_byte = is_pulse ? pulse_byte : r_job.chan[r_cnt[1:0]];
                if (r_cnt == data_last) begin
                    n_cnt = '0;
                    if (r_job.frame_end && TRAILER_BYTES != 0) begin
                        n_phase = PH_TAIL;
                    end else begin
                        job_done = 1'b1;
                    end
                end
            end
            PH_TAIL: begin
                if (r_cnt == CNT_W'(TRAILER_BYTES - 1)) begin
                    job_done = 1'b1;
                end
            end
            default: begin
                job_done = 1'b1;
            end
        endcase
    end

    assign adv   = !r_out_valid || i_out_ready;
    assign emit  = r_busy && adv;
    assign o_pop = i_q_valid && (!r_busy || (emit && job_done));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_DATA;
            r_cnt       <= '0;
        end else begin
            if (adv) begin
                r_out_valid <= emit;
            end
            if (o_pop) begin
                r_busy  <= 1'b1;
                r_phase <= first_phase(i_q_data);
                r_cnt   <= '0;
            end else if (emit) begin
                if (job_done) begin
                    r_busy <= 1'b0;
                end
                r_phase <= n_phase;
                r_cnt   <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_q_data;
        end
        if (emit) begin
            r_out_byte <= cur_byte;
            r_out_last <= job_done;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

endmodule

// ===== hw/rtl/led_pixel_stream_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// led_pixel_stream_encoder_unit
// Turns pixels into the serial byte stream of an addressable RGB(W) LED strip.
//
// i_pix carries one pixel per transaction (color, white, dither, frame flags).
// o_byte carries one stream byte per transaction; run_last marks the last
// byte that a pixel causes. A pixel makes 3 bytes (plain), 4 (brightness
// header), 12 (pulse coded RGB) or 16 (pulse coded RGBW), plus 2 leading zero
// bytes on frame start and 32 trailing zero bytes on frame end.
// The user must write configuration through i_cfg_we / i_cfg_idx /
// i_cfg_data only while the stream is idle; the block does not enforce it.
// Indexes past the register list are ignored. The first byte of a pixel
// passes the job queue, the job register of the sequencer and the output
// register. Throughput: one byte per cycle while the receiver is ready, set
// by the single byte sequencer; the next pixel follows without a gap.
// A two-entry job queue lets pixels be accepted while earlier ones stream.
// Reset loads the register defaults and empties the queue and output stage.
// When the receiver stalls the output byte holds, the queue fills and
// i_pix.ready drops until bytes drain again.
// ----------------------------------------------------------------------------
module led_pixel_stream_encoder_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    lpse_pixel_if.sink                     i_pix,
    lpse_byte_if.source                    o_byte,
    input  logic                           i_cfg_we,
    input  logic [lpse_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lpse_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lpse_pkg::*;

    t_cfg   r_cfg;
    t_pixel pixel;
    t_job   push_job;
    t_job   head_job;
    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_valid;

    // Configuration registers: decode the index, keep only the field bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.led_mode          <= MODE_PLAIN;
            r_cfg.color_order       <= ORD_RGB;
            r_cfg.global_brightness <= 5'd31;
            r_cfg.dither_enable     <= 1'b0;
            r_cfg.dither_phase      <= 2'd0;
            r_cfg.zero_pulse_code   <= 4'd8;
            r_cfg.one_pulse_code    <= 4'd14;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_LED_MODE:    r_cfg.led_mode          <= t_led_mode'(i_cfg_data[1:0]);
                CFG_COLOR_ORDER: r_cfg.color_order       <= i_cfg_data[2:0];
                CFG_BRIGHTNESS:  r_cfg.global_brightness <= i_cfg_data[4:0];
                CFG_DITHER_EN:   r_cfg.dither_enable     <= i_cfg_data[0];
                CFG_DITHER_PH:   r_cfg.dither_phase      <= i_cfg_data[1:0];
                CFG_ZERO_CODE:   r_cfg.zero_pulse_code   <= i_cfg_data[3:0];
                CFG_ONE_CODE:    r_cfg.one_pulse_code    <= i_cfg_data[3:0];
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    // Gather the pixel transaction payload.
    assign pixel.red         = i_pix.red;
    assign pixel.green       = i_pix.green;
    assign pixel.blue        = i_pix.blue;
    assign pixel.white       = i_pix.white;
    assign pixel.dither_bits = i_pix.dither_bits;
    assign pixel.frame_start = i_pix.frame_start;
    assign pixel.frame_end   = i_pix.frame_end;

    // Front: dither and reorder at acceptance.
    lpse_front u_front (
        .i_cfg      (r_cfg),
        .i_in_valid (i_pix.valid),
        .o_in_ready (i_pix.ready),
        .i_pixel    (pixel),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job      (push_job)
    );

    // Queue: decouple acceptance from byte streaming.
    lpse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (head_job),
        .i_pop   (pop)
    );

    // Back: emit one byte per cycle into the output register while the receiver does not stall.
    lpse_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_data    (head_job),
        .o_pop       (pop),
        .o_out_valid (o_byte.valid),
        .i_out_ready (o_byte.ready),
        .o_out_byte  (o_byte.out_byte),
        .o_out_last  (o_byte.run_last)
    );

endmodule

// ===== hw/rtl/lpse_checker.sv =====
// ----------------------------------------------------------------------------
// lpse_checker
// Port-level checks of the LED pixel stream encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "led_pixel_stream_encoder_unit_assert.svh"

module lpse_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);

    // A stalled output transaction stays offered.
    `LPSE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "output valid dropped while stalled")

    // A stalled output transaction keeps its payload.
    `LPSE_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_byte) && $stable(i_out_last), "output payload changed while stalled")

    // An accepted pixel must see output valid once it has passed the queue, job and output registers.
    `LPSE_ASSERT_NEXT(a_in_to_out, i_clk, i_rst_n, i_in_valid && i_in_ready, ##2 i_out_valid, "no output three cycles after a pixel")

    // Reset empties the output stage.
    `LPSE_ASSERT_NEXT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !i_out_valid, "output valid right after reset")

endmodule

bind led_pixel_stream_encoder_unit lpse_checker u_lpse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_byte.valid),
    .i_out_ready (o_byte.ready),
    .i_out_byte  (o_byte.out_byte),
    .i_out_last  (o_byte.run_last)
);

// ===== verif/led_pixel_stream_encoder_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// led_pixel_stream_encoder_unit_test
// Drives pixels into the LED stream encoder and checks every output byte.
// A scoreboard class encodes each accepted pixel into the byte sequence the
// strip should see and compares it, byte by byte, with what the block emits.
// A directed part covers the modes, orders, dither and frame flags; random
// phases follow under changing configurations and handshake pressure.
// ----------------------------------------------------------------------------
module led_pixel_stream_encoder_unit_test;
    import lpse_pkg::*;

    localparam int STALL_LIMIT     = 2000;  // cycles with no transaction at all
    localparam int DRAIN_CYCLES    = 16;    // settle time after the last byte
    localparam int PHASE_ITEMS     = 58;
    localparam int PHASE_COUNT     = 6;
    localparam int PRESSURE_PHASE  = 4;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int REPORT_LIMIT    = 10;

    // Index past the register list; the block must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_strip_byte;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the registers, turns each accepted
    // pixel into the bytes it must produce and checks bytes in arrival order.
    // ------------------------------------------------------------------------
    class strip_byte_scoreboard;
        t_cfg        cfg;
        t_strip_byte bytes_due[$];
        int          bad_bytes;
        int          seen_bytes;

        function new();
            cfg.led_mode          = MODE_PLAIN;
            cfg.color_order       = ORD_RGB;
            cfg.global_brightness = 5'd31;
            cfg.dither_enable     = 1'b0;
            cfg.dither_phase      = 2'd0;
            cfg.zero_pulse_code   = 4'd8;
            cfg.one_pulse_code    = 4'd14;
            bad_bytes  = 0;
            seen_bytes = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_LED_MODE:    cfg.led_mode = t_led_mode'(val[1:0]);
                CFG_COLOR_ORDER: cfg.color_order = val[2:0];
                CFG_BRIGHTNESS:  cfg.global_brightness = val[4:0];
                CFG_DITHER_EN:   cfg.dither_enable = val[0];
                CFG_DITHER_PH:   cfg.dither_phase = val[1:0];
                CFG_ZERO_CODE:   cfg.zero_pulse_code = val[3:0];
                CFG_ONE_CODE:    cfg.one_pulse_code = val[3:0];
                default: ;
            endcase
        endfunction

        function void push_byte(logic [7:0] b);
            t_strip_byte e;
            e.data = b;
            e.last = 1'b0;
            bytes_due.push_back(e);
        endfunction

        // Raise a channel by one, saturating, when its dither value beats the phase.
        function logic [7:0] dither_chan(logic [7:0] v, logic [1:0] d);
            if (v != CHAN_MAX && d > cfg.dither_phase)
                return v + 8'd1;
            return v;
        endfunction

        // Each data bit, MSB first, becomes a four-bit code; two codes per byte.
        function void push_pulse(logic [7:0] v);
            int k;
            for (k = 0; k < 4; k++) begin
                push_byte({v[7-2*k] ? cfg.one_pulse_code : cfg.zero_pulse_code,
                           v[6-2*k] ? cfg.one_pulse_code : cfg.zero_pulse_code});
            end
        endfunction

        function void encode_pixel(t_pixel px);
            logic [7:0] r, g, b;
            logic [2:0][7:0] chan;
            int i;
            r = px.red;
            g = px.green;
            b = px.blue;
            if (px.frame_start)
                for (i = 0; i < HEADER_BYTES; i++)
                    push_byte(8'h00);
            if (cfg.led_mode != MODE_PULSE_W && cfg.dither_enable) begin
                r = dither_chan(r, px.dither_bits[5:4]);
                g = dither_chan(g, px.dither_bits[3:2]);
                b = dither_chan(b, px.dither_bits[1:0]);
            end
            // chan[2] goes out first
            case (cfg.color_order)
                ORD_RBG: chan = {r, b, g};
                ORD_GRB: chan = {g, r, b};
                ORD_BGR: chan = {b, g, r};
                ORD_BRG: chan = {b, r, g};
                ORD_GBR: chan = {g, b, r};
                default: chan = {r, g, b};
            endcase
            if (cfg.led_mode == MODE_PULSE || cfg.led_mode == MODE_PULSE_W) begin
                for (i = 2; i >= 0; i--)
                    push_pulse(chan[i]);
                if (cfg.led_mode == MODE_PULSE_W)
                    push_pulse(px.white);
            end else begin
                if (cfg.led_mode == MODE_BRIGHT)
                    push_byte(BRIGHT_HDR_BASE | {3'b000, cfg.global_brightness});
                for (i = 2; i >= 0; i--)
                    push_byte(chan[i]);
            end
            if (px.frame_end)
                for (i = 0; i < TRAILER_BYTES; i++)
                    push_byte(8'h00);
            bytes_due[bytes_due.size()-1].last = 1'b1;
        endfunction

        function void check_byte(logic [7:0] data, logic last);
            t_strip_byte e;
            seen_bytes++;
            if (bytes_due.size() == 0) begin
                bad_bytes++;
                if (bad_bytes <= REPORT_LIMIT)
                    $display("byte %0d: unexpected, got %02h last %0b", seen_bytes, data, last);
                return;
            end
            e = bytes_due.pop_front();
            if (data !== e.data || last !== e.last) begin
                bad_bytes++;
                if (bad_bytes <= REPORT_LIMIT)
                    $display("byte %0d: expected %02h last %0b, got %02h last %0b",
                             seen_bytes, e.data, e.last, data, last);
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    lpse_pixel_if pix ();
    lpse_byte_if  byt ();

    led_pixel_stream_encoder_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix),
        .o_byte     (byt),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    strip_byte_scoreboard sb = new();

    // Idle/stall percentages for the current phase, and the receiver hold-off.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;

    int send_idle_tbl  [PHASE_COUNT] = '{0, 86, 0, 16, 0, 16};
    int recv_stall_tbl [PHASE_COUNT] = '{0, 0, 86, 16, 0, 16};

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Receiver: decide ready at each falling edge. A pending hold-off wins
    // over the random stall and keeps ready low until it has counted down.
    // ------------------------------------------------------------------------
    initial begin
        byt.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                byt.ready = 1'b0;
                hold_left--;
            end else begin
                byt.ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: sample both channels at the rising edge. A pixel transaction
    // is encoded before any byte of the same edge is checked.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pixel seen;
        if (i_rst_n && pix.valid && pix.ready) begin
            seen.red         = pix.red;
            seen.green       = pix.green;
            seen.blue        = pix.blue;
            seen.white       = pix.white;
            seen.dither_bits = pix.dither_bits;
            seen.frame_start = pix.frame_start;
            seen.frame_end   = pix.frame_end;
            sb.encode_pixel(seen);
        end
        if (i_rst_n && byt.valid && byt.ready)
            sb.check_byte(byt.out_byte, byt.run_last);
    end

    // ------------------------------------------------------------------------
    // Watchdog: count cycles in which neither channel moves a transaction.
    // ------------------------------------------------------------------------
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (pix.valid && pix.ready) || (byt.valid && byt.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    function automatic t_pixel make_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                          logic [7:0] w, logic [5:0] d,
                                          logic fs, logic fe);
        t_pixel p;
        p.red         = r;
        p.green       = g;
        p.blue        = b;
        p.white       = w;
        p.dither_bits = d;
        p.frame_start = fs;
        p.frame_end   = fe;
        return p;
    endfunction

    // Channels lean toward full scale now and then so saturation gets hit.
    function automatic logic [7:0] random_chan();
        if ($urandom_range(7) == 0)
            return CHAN_MAX;
        return 8'($urandom);
    endfunction

    // Mostly well-formed frames; one pixel in ten carries random flags.
    function automatic t_pixel random_pixel(logic fs, logic fe);
        t_pixel p;
        p = make_pixel(random_chan(), random_chan(), random_chan(), 8'($urandom),
                       6'($urandom), fs, fe);
        if ($urandom_range(9) == 0) begin
            p.frame_start = 1'($urandom);
            p.frame_end   = 1'($urandom);
        end
        return p;
    endfunction

    // Offer one pixel, starting from a falling edge; return at the falling
    // edge after its transaction, valid still high for a back-to-back pixel.
    task automatic send_pixel(t_pixel p);
        while ($urandom_range(99) < send_idle_pct) begin
            pix.valid = 1'b0;
            @(negedge i_clk);
        end
        pix.valid       = 1'b1;
        pix.red         = p.red;
        pix.green       = p.green;
        pix.blue        = p.blue;
        pix.white       = p.white;
        pix.dither_bits = p.dither_bits;
        pix.frame_start = p.frame_start;
        pix.frame_end   = p.frame_end;
        do
            @(posedge i_clk);
        while (!pix.ready);
        @(negedge i_clk);
    endtask

    // Drop valid, wait until every expected byte is out, then let the block settle.
    task automatic drain_stream();
        pix.valid = 1'b0;
        while (sb.bytes_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // One register write, issued at a falling edge while the stream is idle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic shuffle_config();
        write_reg(CFG_LED_MODE,    5'($urandom_range(3)));
        write_reg(CFG_COLOR_ORDER, 5'($urandom_range(7)));
        write_reg(CFG_BRIGHTNESS,  5'($urandom_range(31)));
        write_reg(CFG_DITHER_EN,   5'($urandom_range(1)));
        write_reg(CFG_DITHER_PH,   5'($urandom_range(3)));
        write_reg(CFG_ZERO_CODE,   5'($urandom_range(15)));
        write_reg(CFG_ONE_CODE,    5'($urandom_range(15)));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int ph, n, ord, frame_len, frame_left;
        t_pixel p;

        // Hold every input at a known value in reset, then release it.
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_LED_MODE;
        i_cfg_data      = '0;
        pix.valid       = 1'b0;
        pix.red         = '0;
        pix.green       = '0;
        pix.blue        = '0;
        pix.white       = '0;
        pix.dither_bits = '0;
        pix.frame_start = 1'b0;
        pix.frame_end   = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset defaults: plain RGB. Frame start, full scale, then frame end.
        send_pixel(make_pixel(8'h12, 8'h34, 8'h56, 8'h78, 6'h3F, 1'b1, 1'b0));
        send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 6'h00, 1'b0, 1'b0));
        send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 6'h00, 1'b0, 1'b1));

        // Brightness header at both ends of its range; both frame flags at once.
        drain_stream();
        write_reg(CFG_LED_MODE, 5'(MODE_BRIGHT));
        write_reg(CFG_BRIGHTNESS, 5'd0);
        send_pixel(make_pixel(8'hA1, 8'hB2, 8'hC3, 8'h00, 6'h00, 1'b1, 1'b1));
        drain_stream();
        write_reg(CFG_BRIGHTNESS, 5'd31);
        send_pixel(make_pixel(8'h01, 8'h80, 8'h7F, 8'h00, 6'h00, 1'b0, 1'b0));

        // Every order code, the two unused ones included (they fall back to RGB).
        for (ord = 0; ord < 8; ord++) begin
            drain_stream();
            write_reg(CFG_LED_MODE, 5'(MODE_PLAIN));
            write_reg(CFG_COLOR_ORDER, 5'(ord));
            send_pixel(make_pixel(8'h11, 8'h22, 8'h33, 8'h44, 6'h00, 1'b0, 1'b0));
        end

        // Dither: saturation at full scale, strict compare against the phase.
        drain_stream();
        write_reg(CFG_COLOR_ORDER, 5'(ORD_RGB));
        write_reg(CFG_DITHER_EN, 5'd1);
        write_reg(CFG_DITHER_PH, 5'd0);
        send_pixel(make_pixel(8'hFF, 8'hFE, 8'h00, 8'h00, 6'b01_01_00, 1'b0, 1'b0));
        drain_stream();
        write_reg(CFG_DITHER_PH, 5'd3);
        send_pixel(make_pixel(8'h10, 8'h20, 8'h30, 8'h00, 6'b11_11_11, 1'b0, 1'b0));
        drain_stream();
        write_reg(CFG_DITHER_PH, 5'd2);
        send_pixel(make_pixel(8'h10, 8'h20, 8'h30, 8'h00, 6'b11_10_01, 1'b0, 1'b0));

        // Pulse coded RGBW: dither stays enabled but must not apply here.
        drain_stream();
        write_reg(CFG_LED_MODE, 5'(MODE_PULSE_W));
        write_reg(CFG_DITHER_PH, 5'd0);
        send_pixel(make_pixel(8'hA5, 8'h0F, 8'hF0, 8'h5A, 6'h3F, 1'b1, 1'b1));

        // Pulse coded RGB with the codes at their extremes, then swapped.
        drain_stream();
        write_reg(CFG_LED_MODE, 5'(MODE_PULSE));
        write_reg(CFG_DITHER_EN, 5'd0);
        write_reg(CFG_ZERO_CODE, 5'd0);
        write_reg(CFG_ONE_CODE, 5'd15);
        send_pixel(make_pixel(8'h80, 8'h01, 8'hFF, 8'h00, 6'h00, 1'b0, 1'b0));
        drain_stream();
        write_reg(CFG_ZERO_CODE, 5'd15);
        write_reg(CFG_ONE_CODE, 5'd0);
        write_reg(CFG_UNUSED_IDX, 5'd31);
        send_pixel(make_pixel(8'h55, 8'hAA, 8'h00, 8'h00, 6'h00, 1'b0, 1'b0));

        // Random phases: fresh configuration each time, frames of 1..8 pixels.
        for (ph = 0; ph < PHASE_COUNT; ph++) begin
            drain_stream();
            shuffle_config();
            if (ph == PRESSURE_PHASE)
                write_reg(CFG_LED_MODE, 5'(MODE_PULSE_W));
            send_idle_pct  = send_idle_tbl[ph];
            recv_stall_pct = recv_stall_tbl[ph];
            if (ph == PRESSURE_PHASE) begin
                // Starve the output so the job queue fills and input backs up.
                @(posedge i_clk);
                hold_left = HOLD_OFF_CYCLES;
                @(negedge i_clk);
            end
            frame_len  = 1;
            frame_left = 0;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (frame_left == 0) begin
                    frame_len  = $urandom_range(8, 1);
                    frame_left = frame_len;
                end
                p = random_pixel(frame_left == frame_len, frame_left == 1);
                send_pixel(p);
                frame_left--;
            end
        end

        drain_stream();
        if (sb.bad_bytes == 0 && sb.bytes_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/lpse_pkg.sv
hw/rtl/lpse_pixel_if.sv
hw/rtl/lpse_byte_if.sv
hw/rtl/lpse_front.sv
hw/rtl/lpse_queue.sv
hw/rtl/lpse_back.sv
hw/rtl/led_pixel_stream_encoder_unit.sv
hw/rtl/lpse_checker.sv
verif/led_pixel_stream_encoder_unit_test.sv
